@@ hdl/slstm_pkg.sv @@
// ----------------------------------------------------------------------------
// slstm_pkg: shared constants, types and functions of the S-LSTM cell update
// Number format, activation tables built at elaboration, and rounding and
// saturation helpers.
// ----------------------------------------------------------------------------
package slstm_pkg;

   localparam int FRAC_BITS      = 10;   // Q.FRAC_BITS, range 6..14
   localparam int TABLE_SEGMENTS = 256;  // PWL segments over [-8,8), range 16..4096
   localparam int WORD_W         = 16;
   localparam int IN_FIELDS      = 10;
   localparam int OUT_FIELDS     = 2;

   // PWL evaluation widths
   localparam int D_BITS = FRAC_BITS + 4;                                 // D = 16*ONE
   localparam int EXT_W  = ((D_BITS > WORD_W) ? D_BITS : WORD_W) + 2;
   localparam int KW     = $clog2(TABLE_SEGMENTS);
   localparam int TI_W   = $clog2(TABLE_SEGMENTS + 1);
   localparam int Q_W    = D_BITS + KW;
   localparam int DY_W   = WORD_W + 1;
   localparam int M_W    = DY_W + D_BITS + 1;

   // product / sum widths
   localparam int PROD_W = 2 * WORD_W + 1;
   localparam int PR_W   = PROD_W - FRAC_BITS;
   localparam int SAT_W  = PR_W + 2;

   // table generation
   localparam int Q30          = 30;
   localparam int SERIES_TERMS = 20;
   localparam int SQUARINGS    = 4;

   localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1 << (FRAC_BITS - 1));
   localparam logic signed [SAT_W-1:0]  SAT_HI   = SAT_W'((1 << (WORD_W - 1)) - 1);
   localparam logic signed [SAT_W-1:0]  SAT_LO   = SAT_W'(-(1 << (WORD_W - 1)));

   typedef logic [TABLE_SEGMENTS:0][WORD_W-1:0] act_tab_type;

   typedef struct packed {
      logic look;     // lookup stage load
      logic interp;   // interpolation stage load
   } pwl_en_type;

   // shift-subtract divide, elaboration only
   function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
      logic [63:0] quo;
      logic [63:0] rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic [63:0] div_small(logic [63:0] x, logic [4:0] n);
      logic [63:0] res;
      case (n)
         5'd1:    res = x;
         5'd2:    res = x / 64'd2;
         5'd3:    res = x / 64'd3;
         5'd4:    res = x / 64'd4;
         5'd5:    res = x / 64'd5;
         5'd6:    res = x / 64'd6;
         5'd7:    res = x / 64'd7;
         5'd8:    res = x / 64'd8;
         5'd9:    res = x / 64'd9;
         5'd10:   res = x / 64'd10;
         5'd11:   res = x / 64'd11;
         5'd12:   res = x / 64'd12;
         5'd13:   res = x / 64'd13;
         5'd14:   res = x / 64'd14;
         5'd15:   res = x / 64'd15;
         5'd16:   res = x / 64'd16;
         5'd17:   res = x / 64'd17;
         5'd18:   res = x / 64'd18;
         5'd19:   res = x / 64'd19;
         5'd20:   res = x / 64'd20;
         default: res = x;
      endcase
      return res;
   endfunction

   // e^-(y*16) in Q30, y in Q30 within [0,1]
   function automatic logic [63:0] exp_neg_q30(logic [63:0] y);
      logic [63:0]        one_q;
      logic [63:0]        term;
      logic [63:0]        s;
      logic signed [63:0] sum;
      one_q = 64'd1 << Q30;
      term  = one_q;
      sum   = $signed(one_q);
      for (int n = 1; n <= SERIES_TERMS; n++) begin
         term = div_small((term * y) >> Q30, 5'(n));
         if (n[0])
            sum = sum - $signed(term);
         else
            sum = sum + $signed(term);
      end
      if (sum < 0)
         sum = 0;
      if (sum > $signed(one_q))
         sum = $signed(one_q);
      s = $unsigned(sum);
      for (int j = 0; j < SQUARINGS; j++)
         s = (s * s + (one_q >> 1)) >> Q30;
      return s;
   endfunction

   function automatic act_tab_type build_tab(logic is_tanh);
      act_tab_type tab;
      logic [63:0] one_q;
      logic [63:0] mag;
      logic [63:0] xq;
      logic [63:0] e;
      logic [63:0] den;
      logic [63:0] t;
      longint      num;
      logic        neg;
      one_q = 64'd1 << Q30;
      for (int k = 0; k <= TABLE_SEGMENTS; k++) begin
         num = 16 * longint'(k) - 8 * longint'(TABLE_SEGMENTS);
         neg = (num < 0);
         mag = neg ? 64'(-num) : 64'(num);
         xq  = (mag << Q30) / TABLE_SEGMENTS;
         e   = exp_neg_q30(is_tanh ? (xq >> 3) : (xq >> 4));
         den = one_q + e;
         if (is_tanh) begin
            t      = udiv64(((one_q - e) << FRAC_BITS) + (den >> 1), den);
            tab[k] = neg ? WORD_W'(-t) : WORD_W'(t);
         end else begin
            t      = udiv64(((neg ? e : one_q) << FRAC_BITS) + (den >> 1), den);
            tab[k] = WORD_W'(t);
         end
      end
      return tab;
   endfunction

   localparam act_tab_type SIG_TAB  = build_tab(1'b0);
   localparam act_tab_type TANH_TAB = build_tab(1'b1);

   // Q product rounded to nearest, ties up
   function automatic logic signed [PR_W-1:0] round_mul(logic signed [WORD_W-1:0] a,
                                                        logic signed [WORD_W-1:0] b);
      logic signed [PROD_W-1:0] t;
      t = PROD_W'(a) * PROD_W'(b) + RND_HALF;
      return t[PROD_W-1:FRAC_BITS];
   endfunction

   function automatic logic signed [WORD_W-1:0] sat_word(logic signed [SAT_W-1:0] x);
      logic signed [WORD_W-1:0] res;
      if (x > SAT_HI)
         res = SAT_HI[WORD_W-1:0];
      else if (x < SAT_LO)
         res = SAT_LO[WORD_W-1:0];
      else
         res = x[WORD_W-1:0];
      return res;
   endfunction

endpackage

@@ hdl/slstm_pwl.sv @@
// ----------------------------------------------------------------------------
// slstm_pwl: two-stage piecewise-linear activation
// Stage one finds the segment and reads both breakpoints, stage two
// interpolates. Inputs outside [-8,8) take the end breakpoints.
// ----------------------------------------------------------------------------
module slstm_pwl #(
   parameter slstm_pkg::act_tab_type TAB = slstm_pkg::SIG_TAB
) (
   input  logic                                   clock,
   input  slstm_pkg::pwl_en_type                  en,
   input  logic signed [slstm_pkg::WORD_W-1:0]    x,
   output logic signed [slstm_pkg::WORD_W-1:0]    y
);
   import slstm_pkg::*;

   localparam logic signed [EXT_W-1:0] LIM_S  = EXT_W'(1 << (FRAC_BITS + 3));
   localparam logic signed [M_W-1:0]   HALF_D = M_W'(1 << (D_BITS - 1));

   logic signed [EXT_W-1:0]  x_ext;
   logic signed [EXT_W-1:0]  p;
   logic [Q_W-1:0]           q;
   logic [TI_W-1:0]          k0;
   logic [TI_W-1:0]          k1;
   logic signed [WORD_W-1:0] y1;
   logic [D_BITS-1:0]        r_in, r_ff;
   logic signed [WORD_W-1:0] y0_in, y0_ff;
   logic signed [DY_W-1:0]   dy_in, dy_ff;
   logic signed [M_W-1:0]    rr;
   logic signed [M_W-1:0]    prod;
   logic signed [WORD_W-1:0] y_in, y_ff;

   // lookup stage
   always_comb begin
      x_ext = EXT_W'(x);
      p     = x_ext + LIM_S;
      q     = Q_W'(p[D_BITS-1:0]) * Q_W'(TABLE_SEGMENTS);   // q / D and q % D below
      k0    = TI_W'(q[Q_W-1:D_BITS]);
      k1    = k0 + TI_W'(1);
      r_in  = q[D_BITS-1:0];
      if (x_ext < -LIM_S) begin
         k0   = '0;
         k1   = '0;
         r_in = '0;
      end else if (x_ext >= LIM_S) begin
         k0   = TI_W'(TABLE_SEGMENTS);
         k1   = TI_W'(TABLE_SEGMENTS);
         r_in = '0;
      end
      y0_in = TAB[k0];
      y1    = TAB[k1];
      dy_in = DY_W'(y1) - DY_W'(y0_in);
   end

   // interpolation stage: y0 + floor((dy*r + D/2) / D)
   always_comb begin
      rr   = M_W'(r_ff);
      prod = M_W'(dy_ff) * rr + HALF_D;
      y_in = y0_ff + WORD_W'(prod >>> D_BITS);
   end

   always_ff @(posedge clock) begin
      if (en.look) begin
         y0_ff <= y0_in;
         dy_ff <= dy_in;
         r_ff  <= r_in;
      end
      if (en.interp) begin
         y_ff <= y_in;
      end
   end

   assign y = y_ff;

endmodule

@@ hdl/slstm_cell_update.sv @@
// ----------------------------------------------------------------------------
// slstm_cell_update: S-LSTM cell update, one element per transfer
// Two-child S-LSTM cell: c = a1*i1 + a2*i2 + f1*cp1 + f2*cp2 and
// h = sigmoid(o1+o2) * tanh(c), all in signed Q.FRAC_BITS.
// ----------------------------------------------------------------------------
// A request transfer carries the ten 16-bit inputs of one element; a response
// transfer carries cell_new and hidden_new. The datapath is a seven-stage
// pipeline that takes one transfer every cycle while the response side does
// not stall; each response is read from the stage 7 register. Each stage
// holds its own valid bit and loads whenever it is empty or the stage after
// it moves, so bubbles close up and new requests keep coming in while a
// finished response waits on rsp_tready, until every stage is full. req_tready
// is combinational from rsp_tready through that chain of stage enables. The
// sigmoid and tanh breakpoint tables are constants built at elaboration from the package.
// Stages:
//   1  o1+o2 saturate, segment lookup of the seven gate activations
//   2  interpolation of the gate activations
//   3  the four rounded products of c
//   4  sum and saturate -> c
//   5  tanh(c) segment lookup
//   6  tanh(c) interpolation
//   7  o * tanh(c), rounded and saturated -> h, response register
// ----------------------------------------------------------------------------
module slstm_cell_update (
   input  logic                                              clock,
   input  logic                                              reset,
   // cand_pre_one, in_gate_pre_one, forget_pre_one, out_pre_one,
   // cand_pre_two, in_gate_pre_two, forget_pre_two, out_pre_two,
   // cell_prev_one, cell_prev_two (16 bits each, from bit 0 up)
   input  logic [slstm_pkg::IN_FIELDS*slstm_pkg::WORD_W-1:0]  req_tdata,
   input  logic                                              req_tvalid,
   output logic                                              req_tready,
   // cell_new, hidden_new (16 bits each, from bit 0 up)
   output logic [slstm_pkg::OUT_FIELDS*slstm_pkg::WORD_W-1:0] rsp_tdata,
   output logic                                              rsp_tvalid,
   input  logic                                              rsp_tready
);
   import slstm_pkg::*;

   localparam int NST = 7;

   // request field positions
   localparam int FLD_A1  = 0;
   localparam int FLD_I1  = 1;
   localparam int FLD_F1  = 2;
   localparam int FLD_O1  = 3;
   localparam int FLD_A2  = 4;
   localparam int FLD_I2  = 5;
   localparam int FLD_F2  = 6;
   localparam int FLD_O2  = 7;
   localparam int FLD_CP1 = 8;
   localparam int FLD_CP2 = 9;

   // activation lanes
   localparam int LN_A1 = 0;
   localparam int LN_I1 = 1;
   localparam int LN_F1 = 2;
   localparam int LN_A2 = 3;
   localparam int LN_I2 = 4;
   localparam int LN_F2 = 5;
   localparam int LN_OG = 6;
   localparam int LANES = 7;

   logic signed [WORD_W-1:0] fld [IN_FIELDS];
   logic signed [WORD_W:0]   o_sum;
   logic signed [WORD_W-1:0] act_x [LANES];
   logic signed [WORD_W-1:0] act_y [LANES];

   // stage enables and valid bits, index = stage number
   logic [NST:1] en;
   logic [NST:1] vld_in, vld_ff;

   pwl_en_type gate_en;
   pwl_en_type tanh_en;

   logic signed [WORD_W-1:0] cp1_1_ff, cp2_1_ff, cp1_2_ff, cp2_2_ff;
   logic signed [PR_W-1:0]   prod_in [4];
   logic signed [PR_W-1:0]   prod_ff [4];
   logic signed [WORD_W-1:0] og_3_ff, og_4_ff, og_5_ff, og_6_ff;
   logic signed [WORD_W-1:0] c_4_in, c_4_ff, c_5_ff, c_6_ff;
   logic signed [WORD_W-1:0] tanh_c;
   logic signed [WORD_W-1:0] cell_ff;
   logic signed [WORD_W-1:0] hidden_in, hidden_ff;

   // ---- handshake: a stage loads when empty or when the next one loads ----
   always_comb begin
      en[NST] = !vld_ff[NST] || rsp_tready;
      for (int i = NST - 1; i >= 1; i--)
         en[i] = !vld_ff[i] || en[i+1];
      vld_in = {vld_ff[NST-1:1], req_tvalid};
   end

   assign req_tready = en[1];
   assign rsp_tvalid = vld_ff[NST];
   assign rsp_tdata  = {hidden_ff, cell_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 1; i <= NST; i++)
            if (en[i])
               vld_ff[i] <= vld_in[i];
      end
   end

   // ---- stage 1/2: gate activations ----
   always_comb begin
      for (int i = 0; i < IN_FIELDS; i++)
         fld[i] = req_tdata[WORD_W*i +: WORD_W];
      o_sum = (WORD_W+1)'(fld[FLD_O1]) + (WORD_W+1)'(fld[FLD_O2]);
      act_x[LN_A1] = fld[FLD_A1];
      act_x[LN_I1] = fld[FLD_I1];
      act_x[LN_F1] = fld[FLD_F1];
      act_x[LN_A2] = fld[FLD_A2];
      act_x[LN_I2] = fld[FLD_I2];
      act_x[LN_F2] = fld[FLD_F2];
      act_x[LN_OG] = sat_word(SAT_W'(o_sum));   // o1+o2 saturates before sigmoid
   end

   assign gate_en = '{look: en[1], interp: en[2]};
   assign tanh_en = '{look: en[5], interp: en[6]};

   for (genvar g = 0; g < LANES; g++) begin : gen_gate
      slstm_pwl #(
         .TAB ((g == LN_A1 || g == LN_A2) ? TANH_TAB : SIG_TAB)
      ) u_pwl (
         .clock (clock),
         .en    (gate_en),
         .x     (act_x[g]),
         .y     (act_y[g])
      );
   end

   // ---- stage 3: rounded products ----
   always_comb begin
      prod_in[0] = round_mul(act_y[LN_A1], act_y[LN_I1]);
      prod_in[1] = round_mul(act_y[LN_A2], act_y[LN_I2]);
      prod_in[2] = round_mul(act_y[LN_F1], cp1_2_ff);
      prod_in[3] = round_mul(act_y[LN_F2], cp2_2_ff);
   end

   // ---- stage 4: exact sum, then saturate ----
   assign c_4_in = sat_word(SAT_W'(prod_ff[0]) + SAT_W'(prod_ff[1]) +
                            SAT_W'(prod_ff[2]) + SAT_W'(prod_ff[3]));

   // ---- stage 5/6: tanh(c) ----
   slstm_pwl #(
      .TAB (TANH_TAB)
   ) u_tanh_c (
      .clock (clock),
      .en    (tanh_en),
      .x     (c_4_ff),
      .y     (tanh_c)
   );

   // ---- stage 7: h ----
   assign hidden_in = sat_word(SAT_W'(round_mul(og_6_ff, tanh_c)));

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (en[1]) begin
         cp1_1_ff <= fld[FLD_CP1];
         cp2_1_ff <= fld[FLD_CP2];
      end
      if (en[2]) begin
         cp1_2_ff <= cp1_1_ff;
         cp2_2_ff <= cp2_1_ff;
      end
      if (en[3]) begin
         for (int i = 0; i < 4; i++)
            prod_ff[i] <= prod_in[i];
         og_3_ff <= act_y[LN_OG];
      end
      if (en[4]) begin
         c_4_ff  <= c_4_in;
         og_4_ff <= og_3_ff;
      end
      if (en[5]) begin
         c_5_ff  <= c_4_ff;
         og_5_ff <= og_4_ff;
      end
      if (en[6]) begin
         c_6_ff  <= c_5_ff;
         og_6_ff <= og_5_ff;
      end
      if (en[7]) begin
         cell_ff   <= c_6_ff;
         hidden_ff <= hidden_in;
      end
   end

endmodule
